>>> rtl/w8u16_pkg.sv
// Shared types and constants of the WTF-8 to UTF-16 decoder.
package w8u16_pkg;

	localparam int unsigned FIFO_DEPTH = 4;

	localparam logic [7:0]  ASCII_MAX   = 8'h7F;
	localparam logic [7:0]  CONT_MIN    = 8'h80;
	localparam logic [7:0]  CONT_MAX    = 8'hBF;
	localparam logic [7:0]  LEAD2_MIN   = 8'hC2;
	localparam logic [7:0]  LEAD2_MAX   = 8'hDF;
	localparam logic [7:0]  LEAD3_MIN   = 8'hE0;
	localparam logic [7:0]  LEAD3_MAX   = 8'hEF;
	localparam logic [7:0]  LEAD4_MIN   = 8'hF0;
	localparam logic [7:0]  LEAD4_MAX   = 8'hF4;

	localparam logic [20:0] CP_MIN2     = 21'h00080;
	localparam logic [20:0] CP_MIN3     = 21'h00800;
	localparam logic [20:0] CP_MIN4     = 21'h10000;
	localparam logic [20:0] CP_MAX      = 21'h10FFFF;
	localparam logic [15:0] HI_SURR     = 16'hD800;
	localparam logic [15:0] LO_SURR     = 16'hDC00;
	localparam logic [9:0]  SURR_MASK   = 10'h3FF;

	localparam logic [2:0]  SEQ_LEN2    = 3'd2;
	localparam logic [2:0]  SEQ_LEN3    = 3'd3;
	localparam logic [2:0]  SEQ_LEN4    = 3'd4;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_string;
	} req_t;

	typedef struct packed {
		logic [15:0] unit;
		logic        has_unit;
		logic        malformed;
		logic        string_done;
		logic        last_of_run;
	} rsp_t;

	typedef struct packed {
		logic [1:0] count;
		rsp_t       first;
		rsp_t       second;
	} step_res_t;

endpackage

>>> rtl/w8u16_decode.sv
// Byte decoder: sequence state, validation and UTF-16 unit generation.
module w8u16_decode (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  w8u16_pkg::req_t    req,
	output w8u16_pkg::step_res_t res
);

	logic [20:0] acc_q;
	logic [1:0]  rem_q;
	logic [2:0]  len_q;
	logic        err_q;

	logic [20:0] acc_n;
	logic [1:0]  rem_n;
	logic [2:0]  len_n;
	logic        err_n;

	logic [20:0] acc_shift;
	logic [20:0] cp;
	logic [20:0] v;
	logic        bad;
	logic        done;
	logic        eos;
	logic [7:0]  b;
	logic [15:0] u0;
	logic [15:0] u1;
	logic        pair;

	assign b         = req.data_byte;
	assign eos       = req.end_of_string;
	assign acc_shift = {acc_q[14:0], b[5:0]};
	assign v         = cp - w8u16_pkg::CP_MIN4;

	always_comb begin
		acc_n = acc_q;
		rem_n = rem_q;
		len_n = len_q;
		err_n = err_q;
		cp    = '0;
		bad   = 1'b0;
		done  = 1'b0;
		if (!err_q) begin
			if (rem_q == 2'd0) begin
				if (b <= w8u16_pkg::ASCII_MAX) begin
					cp   = {13'd0, b};
					done = 1'b1;
				end else if (b inside {[w8u16_pkg::LEAD2_MIN:w8u16_pkg::LEAD2_MAX]}) begin
					acc_n = {16'd0, b[4:0]};
					len_n = w8u16_pkg::SEQ_LEN2;
					rem_n = 2'd1;
				end else if (b inside {[w8u16_pkg::LEAD3_MIN:w8u16_pkg::LEAD3_MAX]}) begin
					acc_n = {17'd0, b[3:0]};
					len_n = w8u16_pkg::SEQ_LEN3;
					rem_n = 2'd2;
				end else if (b inside {[w8u16_pkg::LEAD4_MIN:w8u16_pkg::LEAD4_MAX]}) begin
					acc_n = {18'd0, b[2:0]};
					len_n = w8u16_pkg::SEQ_LEN4;
					rem_n = 2'd3;
				end else begin
					bad = 1'b1;
				end
			end else if (b inside {[w8u16_pkg::CONT_MIN:w8u16_pkg::CONT_MAX]}) begin
				acc_n = acc_shift;
				rem_n = rem_q - 2'd1;
				if (rem_n == 2'd0) begin
					cp = acc_shift;
					if ((len_q == w8u16_pkg::SEQ_LEN2 && cp < w8u16_pkg::CP_MIN2) ||
					    (len_q == w8u16_pkg::SEQ_LEN3 && cp < w8u16_pkg::CP_MIN3) ||
					    (len_q == w8u16_pkg::SEQ_LEN4 &&
					     (cp < w8u16_pkg::CP_MIN4 || cp > w8u16_pkg::CP_MAX))) begin
						bad = 1'b1;
					end else begin
						done = 1'b1;
					end
					acc_n = '0;
					len_n = '0;
				end
			end else begin
				bad = 1'b1;
			end
			if (!bad && eos && rem_n != 2'd0) begin
				bad = 1'b1;
			end
			if (bad) begin
				err_n = 1'b1;
				acc_n = '0;
				rem_n = '0;
				len_n = '0;
			end
		end
	end

	assign pair = cp >= w8u16_pkg::CP_MIN4;
	assign u0   = pair ? (w8u16_pkg::HI_SURR + {6'd0, v[19:10] & w8u16_pkg::SURR_MASK})
	                   : cp[15:0];
	assign u1   = w8u16_pkg::LO_SURR + {6'd0, v[9:0] & w8u16_pkg::SURR_MASK};

	always_comb begin
		res = '0;
		if (done) begin
			res.first.unit     = u0;
			res.first.has_unit = 1'b1;
			if (pair) begin
				res.count              = 2'd2;
				res.second.unit        = u1;
				res.second.has_unit    = 1'b1;
				res.second.string_done = eos;
				res.second.last_of_run = 1'b1;
			end else begin
				res.count             = 2'd1;
				res.first.string_done = eos;
				res.first.last_of_run = 1'b1;
			end
		end else if (eos) begin
			res.count             = 2'd1;
			res.first.malformed   = err_n;
			res.first.string_done = 1'b1;
			res.first.last_of_run = 1'b1;
		end else if (bad) begin
			res.count             = 2'd1;
			res.first.malformed   = 1'b1;
			res.first.last_of_run = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			rem_q <= '0;
			len_q <= '0;
			err_q <= 1'b0;
		end else if (step) begin
			if (eos) begin
				acc_q <= '0;
				rem_q <= '0;
				len_q <= '0;
				err_q <= 1'b0;
			end else begin
				acc_q <= acc_n;
				rem_q <= rem_n;
				len_q <= len_n;
				err_q <= err_n;
			end
		end
	end

endmodule

>>> rtl/w8u16_out_fifo.sv
// Result queue: takes up to two results per cycle, hands out one while out_ready is high.
module w8u16_out_fifo #(
	parameter int unsigned DEPTH = w8u16_pkg::FIFO_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  w8u16_pkg::step_res_t  res,
	output logic                  room,
	output logic                  out_valid,
	input  logic                  out_ready,
	output w8u16_pkg::rsp_t       out_rsp
);

	localparam int unsigned PW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] ROOM_MAX = CW'(DEPTH - 2);

	w8u16_pkg::rsp_t mem_q [DEPTH];
	logic [PW-1:0] head_q;
	logic [PW-1:0] tail_q;
	logic [CW-1:0] count_q;
	logic [1:0]    n_push;
	logic          pop;
	logic [PW-1:0] tail_p1;

	assign n_push    = push ? res.count : 2'd0;
	assign pop       = out_valid && out_ready;
	assign out_valid = count_q != '0;
	assign out_rsp   = mem_q[head_q];
	assign room      = count_q <= ROOM_MAX;
	assign tail_p1   = tail_q + PW'(1);

	always_ff @(posedge clk) begin
		if (n_push != 2'd0) begin
			mem_q[tail_q] <= res.first;
		end
		if (n_push == 2'd2) begin
			mem_q[tail_p1] <= res.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (pop) begin
				head_q <= head_q + PW'(1);
			end
			tail_q  <= tail_q + PW'(n_push);
			count_q <= count_q + CW'(n_push) - CW'(pop);
		end
	end

endmodule

>>> rtl/wtf8_decoder_to_utf16.sv
// Top level of the WTF-8 to UTF-16 decoder.
//
// Input channel in_valid/in_ready/in_req carries one WTF-8 byte per request,
// with end_of_string on the last byte of a string. Output channel
// out_valid/out_ready/out_rsp carries one result per request: a UTF-16 unit,
// an error notice, or the final verdict of a string (string_done), with
// last_of_run on the last result caused by a byte.
// A byte is taken into the input register and decoded from there once the
// queue has room; its results are written into a result queue of FIFO_DEPTH
// entries, and the first result is offered only after it is registered there.
// Throughput is one byte per cycle; a 4-byte sequence yields a surrogate pair,
// and those two results leave one after the other at the output. A byte is
// decoded only while the queue has room for two results.
// Reset clears the decode state and empties the queue and input register.
// When the receiver stalls, results stay in the queue and in_ready drops once
// the input register holds a byte and the queue lacks room for two results.
module wtf8_decoder_to_utf16 #(
	parameter int unsigned FIFO_DEPTH = w8u16_pkg::FIFO_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  w8u16_pkg::req_t in_req,
	output logic            out_valid,
	input  logic            out_ready,
	output w8u16_pkg::rsp_t out_rsp
);

	logic                 vld_s1;
	w8u16_pkg::req_t      req_s1;
	logic                 room;
	logic                 step;
	w8u16_pkg::step_res_t res;

	assign step     = vld_s1 && room;
	assign in_ready = !vld_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			req_s1 <= in_req;
		end
	end

	w8u16_decode u_decode (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.req    (req_s1),
		.res    (res)
	);

	w8u16_out_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (step),
		.res       (res),
		.room      (room),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_rsp   (out_rsp)
	);

endmodule
